// ===== hdl/irn_pkg.sv =====
// ----------------------------------------------------------------------------
// irn_pkg: shared types, constants and functions of the roman numeral unit
// Field widths, reciprocal constants for the decimal split, the command and
// status bundles between controller and datapath, and the symbol tables.
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int VALUE_W  = 14;
  localparam int SYMBOL_W = 3;

  // largest legal symbol code (M)
  localparam logic [SYMBOL_W-1:0] SYM_MAX = 3'd6;

  // reciprocal multipliers, exact over the whole 14-bit input range
  localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
  localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
  localparam logic [14:0] RECIP_1000 = 15'd16778;  // >> 24
  localparam logic [VALUE_W-1:0] TEN_THOUSAND = 14'd10000;

  typedef struct packed {
    logic load;   // input item taken, capture quotients
    logic split;  // form digits and pick the first place
    logic step;   // current symbol taken by the receiver
  } irn_cmd_t;

  typedef struct packed {
    logic any;      // split digits give at least one symbol
    logic run_end;  // current symbol closes the run
  } irn_sts_t;

  // number of symbols for digit d; top marks the thousands place
  function automatic logic [2:0] run_len(input logic [3:0] d, input logic top);
    logic [2:0] n;
    n = 3'd0;
    if (top) begin
      if (d >= 4'd1 && d <= 4'd3) n = d[2:0];
    end else begin
      priority if (d == 4'd0) n = 3'd0;
      else if (d <= 4'd3) n = d[2:0];
      else if (d == 4'd4) n = 3'd2;
      else if (d <= 4'd8) n = 3'(d - 4'd4);
      else n = 3'd2;
    end
    return n;
  endfunction

  // symbol k of digit d at place p; one, five, ten of place p are 2p, 2p+1, 2p+2
  function automatic logic [SYMBOL_W-1:0] sym_code(input logic [3:0] d,
                                                   input logic [1:0] p,
                                                   input logic [1:0] k);
    logic [SYMBOL_W-1:0] one;
    logic [SYMBOL_W-1:0] five;
    logic [SYMBOL_W-1:0] ten;
    logic [SYMBOL_W-1:0] s;
    one  = {p, 1'b0};
    five = {p, 1'b1};
    ten  = one + 3'd2;
    priority if (d <= 4'd3) s = one;
    else if (d == 4'd4) s = (k == 2'd0) ? one : five;
    else if (d <= 4'd8) s = (k == 2'd0) ? five : one;
    else s = (k == 2'd0) ? one : ten;
    return s;
  endfunction

endpackage

// ===== hdl/irn_if.sv =====
// ----------------------------------------------------------------------------
// irn channel interfaces
// Valid/ready channels for the input value and for the output symbols.
// ----------------------------------------------------------------------------
interface irn_in_if;
  logic                           valid;
  logic                           ready;
  logic [irn_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface irn_out_if;
  logic                           valid;
  logic                           ready;
  logic [irn_pkg::SYMBOL_W-1:0]   symbol;
  logic                           last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// ===== hdl/integer_to_roman_numeral_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_unit: integer to roman numeral converter
// Turns one unsigned value into its run of roman symbols, thousands first.
// ----------------------------------------------------------------------------
// usage:
//   din  carries one 14-bit value per item (valid/ready, taken when both high)
//   dout carries the symbols (0=I 1=V 2=X 3=L 4=C 5=D 6=M), one per item,
//        with last set on the final symbol of the run; zero gives no symbols
//   a thousands digit of four to nine emits nothing for that place
// timing:
//   the cycle after an item is taken its quotients are turned into digits,
//   and the first symbol is shown the cycle after that
//   symbols then leave one per cycle while dout is ready; the next item is
//   taken on the same edge as the final symbol of the previous one
//   a value with no symbols goes through the split and back to accepting
// stall:
//   during a run, while dout is not ready the current symbol holds and no item is taken
// reset:
//   rst (synchronous) drops any run in progress and returns to accepting
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_unit (
  input  logic      clk,
  input  logic      rst,
  irn_in_if.sink    din,
  irn_out_if.source dout
);

  irn_pkg::irn_cmd_t cmd;
  irn_pkg::irn_sts_t sts;

  irn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  irn_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .value  (din.value),
    .cmd    (cmd),
    .sts    (sts),
    .symbol (dout.symbol),
    .last   (dout.last)
  );

endmodule

// ===== hdl/irn_ctrl.sv =====
// ----------------------------------------------------------------------------
// irn_ctrl: sequencing state machine
// Takes an item, lets the datapath split it, then walks the symbol run one
// symbol per accepted output; the next item may enter on the final symbol.
// ----------------------------------------------------------------------------
module irn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  irn_pkg::irn_sts_t sts,
  output irn_pkg::irn_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SPLIT = 3'b010,
    ST_EMIT  = 3'b100
  } irn_state_t;

  irn_state_t state;
  irn_state_t state_next;

  logic emit;
  assign emit      = (state == ST_EMIT);
  assign out_valid = emit;
  assign in_ready  = (state == ST_IDLE) || (emit && sts.run_end && out_ready);

  assign cmd.load  = in_valid && in_ready;
  assign cmd.split = (state == ST_SPLIT);
  assign cmd.step  = emit && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        state_next = sts.any ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (cmd.step && sts.run_end) state_next = cmd.load ? ST_SPLIT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // no symbol is shown in the cycle after a run closes
  a_gap_after_final: assert property (@(posedge clk) disable iff (rst)
    cmd.step && sts.run_end |=> !out_valid)
    else $error("output still valid after final symbol");

  // a new item only enters during a run when its final symbol leaves
  a_load_on_final: assert property (@(posedge clk) disable iff (rst)
    cmd.load && emit |-> sts.run_end && out_ready)
    else $error("item taken in the middle of a run");

  // after the split the block either emits or is free again
  a_split_exit: assert property (@(posedge clk) disable iff (rst)
    cmd.split |=> out_valid || in_ready)
    else $error("split cycle left in a dead state");
`endif

endmodule

// ===== hdl/irn_datapath.sv =====
// ----------------------------------------------------------------------------
// irn_datapath: decimal split and symbol generation
// Captures reciprocal quotients of the value, forms the four digits, then
// tracks the current place and symbol index of the run.
// ----------------------------------------------------------------------------
module irn_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [irn_pkg::VALUE_W-1:0]     value,
  input  irn_pkg::irn_cmd_t               cmd,
  output irn_pkg::irn_sts_t               sts,
  output logic [irn_pkg::SYMBOL_W-1:0]    symbol,
  output logic                            last
);

  logic [13:0] val;
  logic [10:0] q1;   // value / 10
  logic [7:0]  q2;   // value / 100
  logic [4:0]  q3;   // value / 1000
  logic        q4;   // value / 10000

  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [28:0] prod1000;

  assign prod10   = 30'(value) * 30'(irn_pkg::RECIP_10);
  assign prod100  = 27'(value) * 27'(irn_pkg::RECIP_100);
  assign prod1000 = 29'(value) * 29'(irn_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= value;
      q1  <= prod10[29:19];
      q2  <= prod100[26:19];
      q3  <= prod1000[28:24];
      q4  <= (value >= irn_pkg::TEN_THOUSAND);
    end
  end

  // digits from neighbouring quotients, shift-and-add only
  logic [3:0] new_dig [4];
  logic [3:0] new_nz;
  logic [1:0] new_start;

  always_comb begin
    new_dig[0] = 4'(val - 14'(q1) * 14'd10);
    new_dig[1] = 4'(q1 - 11'(q2) * 11'd10);
    new_dig[2] = 4'(q2 - 8'(q3) * 8'd10);
    new_dig[3] = 4'(q3 - 5'(q4) * 5'd10);
    for (int j = 0; j < 4; j++) begin
      new_nz[j] = (irn_pkg::run_len(new_dig[j], j == 3) != 3'd0);
    end
    priority if (new_nz[3]) new_start = 2'd3;
    else if (new_nz[2]) new_start = 2'd2;
    else if (new_nz[1]) new_start = 2'd1;
    else new_start = 2'd0;
  end

  logic [3:0] dig [4];
  logic [1:0] place;
  logic [1:0] idx;

  logic [3:0] nz;
  logic [3:0] cur_dig;
  logic [2:0] cur_len;
  logic       digit_end;
  logic       lower_any;
  logic [1:0] lower_place;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      nz[j] = (irn_pkg::run_len(dig[j], j == 3) != 3'd0);
    end
    cur_dig   = dig[place];
    cur_len   = irn_pkg::run_len(cur_dig, place == 2'd3);
    digit_end = (3'(idx) == cur_len - 3'd1);
    lower_any   = 1'b0;
    lower_place = 2'd0;
    priority if (place > 2'd2 && nz[2]) begin
      lower_any   = 1'b1;
      lower_place = 2'd2;
    end else if (place > 2'd1 && nz[1]) begin
      lower_any   = 1'b1;
      lower_place = 2'd1;
    end else if (place > 2'd0 && nz[0]) begin
      lower_any   = 1'b1;
      lower_place = 2'd0;
    end else begin
      lower_any   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      for (int j = 0; j < 4; j++) begin
        dig[j] <= new_dig[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      place <= 2'd0;
      idx   <= 2'd0;
    end else if (cmd.split) begin
      place <= new_start;
      idx   <= 2'd0;
    end else if (cmd.step) begin
      if (digit_end) begin
        place <= lower_place;
        idx   <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  assign symbol      = irn_pkg::sym_code(cur_dig, place, idx);
  assign last        = digit_end && !lower_any;
  assign sts.any     = |new_nz;
  assign sts.run_end = last;

`ifndef SYNTHESIS
  // symbol codes stay within I..M while a run is shown
  a_symbol_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> symbol <= irn_pkg::SYM_MAX)
    else $error("symbol code out of range");

  // places are walked from thousands down, never back up
  a_place_down: assert property (@(posedge clk) disable iff (rst)
    cmd.step && !last |=> place <= $past(place))
    else $error("place moved upward within a run");

  // the symbol index stays inside the current digit's run
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> 3'(idx) < cur_len)
    else $error("symbol index beyond digit run");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the integer to roman numeral unit
// Feeds values through the din channel from a queue and predicts the symbol
// run of each item taken. Every symbol seen on dout is checked in order
// against that prediction. Both channels idle at random, with one calm
// stretch, and the sender holds off twice until all symbols are back.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VALUE_W      = irn_pkg::VALUE_W;
  localparam int SYMBOL_W     = irn_pkg::SYMBOL_W;
  localparam int RANDOM_ITEMS = 238;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 24;
  localparam int MAX_REPORTS  = 30;

  // one roman symbol with its end-of-run flag
  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } roman_sym_t;

  // one value waiting to be driven
  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 pause;  // hold off until every symbol is back
    bit                 calm;   // no idling on either side
  } value_item_t;

  logic clk;
  logic rst;

  irn_in_if  din_if ();
  irn_out_if dout_if ();

  integer_to_roman_numeral_unit i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  value_item_t values_pending[$];
  roman_sym_t  symbols_due[$];

  logic drained;
  logic calm;
  int   err_cnt;
  int   values_taken;
  int   symbols_checked;
  int   silent_values;
  int   cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void push_symbol(input logic [SYMBOL_W-1:0] sym);
    roman_sym_t s;
    s.symbol = sym;
    s.last   = 1'b0;
    symbols_due.push_back(s);
  endfunction

  // symbols of decimal digit d at place p (0 units .. 3 thousands)
  function automatic int digit_symbols(input int unsigned d, input int unsigned p);
    logic [SYMBOL_W-1:0] one;
    logic [SYMBOL_W-1:0] five;
    logic [SYMBOL_W-1:0] ten;
    int                  cnt;
    one  = SYMBOL_W'(2 * p);
    five = one + 1'b1;
    ten  = one + 2'd2;
    cnt  = 0;
    if (p == 3) begin
      // a thousands digit beyond three gives nothing
      if (d >= 1 && d <= 3) begin
        for (int i = 0; i < d; i++) push_symbol(one);
        cnt = d;
      end
    end else if (d == 0) begin
      cnt = 0;
    end else if (d <= 3) begin
      for (int i = 0; i < d; i++) push_symbol(one);
      cnt = d;
    end else if (d == 4) begin
      push_symbol(one);
      push_symbol(five);
      cnt = 2;
    end else if (d <= 8) begin
      push_symbol(five);
      for (int i = 5; i < d; i++) push_symbol(one);
      cnt = d - 4;
    end else begin
      push_symbol(one);
      push_symbol(ten);
      cnt = 2;
    end
    return cnt;
  endfunction

  function automatic int predict_numeral(input logic [VALUE_W-1:0] v);
    int unsigned n;
    int          cnt;
    roman_sym_t  tail;
    n   = v;
    cnt = digit_symbols((n / 1000) % 10, 3);
    cnt += digit_symbols((n / 100) % 10, 2);
    cnt += digit_symbols((n / 10) % 10, 1);
    cnt += digit_symbols(n % 10, 0);
    if (cnt > 0) begin
      tail = symbols_due.pop_back();
      tail.last = 1'b1;
      symbols_due.push_back(tail);
    end
    return cnt;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned pick;
    int unsigned acc;
    int unsigned d;
    pick = $urandom_range(99);
    acc  = 0;
    if (pick < 5) begin
      acc = 0;
    end else if (pick < 20) begin
      // above the nominal range, upper bits set
      acc = $urandom_range(16383, 10000);
    end else if (pick < 40) begin
      // digits with long runs
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(3))
          0: d = 3;
          1: d = 7;
          2: d = 8;
          default: d = $urandom_range(9);
        endcase
        if (i == 0 && $urandom_range(3) != 0) d = $urandom_range(3, 1);
        acc = acc * 10 + d;
      end
    end else begin
      acc = $urandom_range(9999);
    end
    return VALUE_W'(acc);
  endfunction

  function automatic void queue_value(input logic [VALUE_W-1:0] v, input bit pause,
                                      input bit quiet);
    value_item_t it;
    it.value = v;
    it.pause = pause;
    it.calm  = quiet;
    values_pending.push_back(it);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_values
    value_item_t nxt;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || din_if.ready) begin
      if (values_pending.size() != 0 &&
          (!values_pending[0].pause || (!din_if.valid && drained)) &&
          (values_pending[0].calm || $urandom_range(99) >= 25)) begin
        nxt = values_pending.pop_front();
        din_if.valid <= 1'b1;
        din_if.value <= nxt.value;
        calm         <= nxt.calm;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    dout_if.ready <= calm || ($urandom_range(99) >= 25);
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_symbols
    roman_sym_t want;
    if (!rst) begin
      if (dout_if.valid && dout_if.ready) begin
        if (symbols_due.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: unexpected symbol, expected none, actual symbol %0d last %0b",
                     $time, dout_if.symbol, dout_if.last);
          err_cnt++;
        end else begin
          want = symbols_due.pop_front();
          if (want.symbol !== dout_if.symbol) begin
            if (err_cnt < MAX_REPORTS)
              $display("%0t: symbol mismatch, expected %0d, actual %0d",
                       $time, want.symbol, dout_if.symbol);
            err_cnt++;
          end
          if (want.last !== dout_if.last) begin
            if (err_cnt < MAX_REPORTS)
              $display("%0t: last mismatch, expected %0b, actual %0b",
                       $time, want.last, dout_if.last);
            err_cnt++;
          end
          symbols_checked++;
        end
      end
      if (din_if.valid && din_if.ready) begin
        if (predict_numeral(din_if.value) == 0) silent_values++;
        values_taken++;
      end
    end
    drained <= (symbols_due.size() == 0);
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: cycle limit reached with %0d symbols outstanding",
             $time, symbols_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [VALUE_W-1:0] directed[$];
    int                 idx;
    rst             = 1'b1;
    din_if.valid    = 1'b0;
    din_if.value    = '0;
    dout_if.ready   = 1'b0;
    drained         = 1'b1;
    calm            = 1'b0;
    err_cnt         = 0;
    values_taken    = 0;
    symbols_checked = 0;
    silent_values   = 0;

    // zero, digit forms, place boundaries, longest run, thousands beyond three,
    // values above 9999 and the all-ones input
    directed = '{14'd0, 14'd1, 14'd4, 14'd5, 14'd8, 14'd9, 14'd40, 14'd90,
                 14'd400, 14'd900, 14'd1000, 14'd3000, 14'd3888, 14'd3999,
                 14'd4000, 14'd9999, 14'd10000, 14'd12000, 14'd16383,
                 14'd1494, 14'd2678, 14'd0};
    foreach (directed[i]) queue_value(directed[i], 1'b0, 1'b0);
    for (idx = 0; idx < RANDOM_ITEMS; idx++)
      queue_value(random_value(), (idx == 90 || idx == 200),
                  (idx >= 120 && idx < 170));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (values_pending.size() != 0 || din_if.valid || !drained);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (symbols_due.size() != 0) begin
      $display("%0t: %0d symbols never arrived, expected symbol %0d, actual none",
               $time, symbols_due.size(), symbols_due[0].symbol);
      err_cnt++;
    end

    $display("run covered %0d values (%0d with no symbols) and %0d symbols checked",
             values_taken, silent_values, symbols_checked);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/irn_pkg.sv
hdl/irn_if.sv
hdl/irn_ctrl.sv
hdl/irn_datapath.sv
hdl/integer_to_roman_numeral_unit.sv
sim/tb_top.sv
